/* rtl/core/sawtooth_modulated_flanger_macros.svh */
`ifndef SAWTOOTH_MODULATED_FLANGER_MACROS_SVH
`define SAWTOOTH_MODULATED_FLANGER_MACROS_SVH

// same-cycle implication
`define SMF_ASSERT_SAME(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("check failed: same-cycle implication");

// next-cycle implication
`define SMF_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("check failed: next-cycle implication");

`endif

/* rtl/core/smf_pkg.sv */
`default_nettype none

package smf_pkg;

  localparam int DEPTH_W    = 18;
  localparam int PREDELAY_W = 19;
  localparam int RATE_W     = 32;
  localparam int PHASE_W    = 32;
  localparam int BIASED_W   = 19;
  localparam int BASE_W     = 21;
  localparam int FRAC_W     = 8;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  localparam logic [RATE_W-1:0] RATE_RESET = 32'd8948;

  localparam logic [1:0] REG_DEPTH    = 2'd0;
  localparam logic [1:0] REG_PREDELAY = 2'd1;
  localparam logic [1:0] REG_RATE     = 2'd2;

  typedef struct packed {
    logic accept;
    logic load_mod;
    logic load_addr;
    logic finish;
  } smf_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/smf_ctrl.sv */
`default_nettype none

module smf_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire              out_ready,
  output smf_pkg::smf_cmd_t cmd
);
  import smf_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_MOD    = 2'd1;
  localparam logic [1:0] S_ADDR   = 2'd2;
  localparam logic [1:0] S_INTERP = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE) && !rst;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd.accept    = in_valid && in_ready;
    cmd.load_mod  = (state == S_MOD);
    cmd.load_addr = (state == S_ADDR);
    cmd.finish    = (state == S_INTERP) && out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.accept) state_next = S_MOD;
      end
      S_MOD:    state_next = S_ADDR;
      S_ADDR:   state_next = S_INTERP;
      S_INTERP: begin
        if (out_free) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/smf_datapath.sv */
`default_nettype none

module smf_datapath #(
  parameter int DELAY_DEPTH = 2048,
  parameter int SAMPLE_BITS = 24
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  smf_pkg::smf_cmd_t                   cmd,
  input  wire        [smf_pkg::DEPTH_W-1:0]    depth_q8,
  input  wire        [smf_pkg::PREDELAY_W-1:0] predelay_q8,
  input  wire        [smf_pkg::RATE_W-1:0]     rate_increment,
  input  wire signed [SAMPLE_BITS-1:0]        sample_in,
  output logic signed [SAMPLE_BITS-1:0]       sample_out
);
  import smf_pkg::*;

  localparam int AW    = $clog2(DELAY_DEPTH);
  localparam int PW    = AW + FRAC_W;
  localparam int XW    = PW + BASE_W + 2;
  localparam int PRODW = DEPTH_W + PHASE_W;
  localparam int SW    = SAMPLE_BITS + FRAC_W + 2;

  logic signed [SAMPLE_BITS-1:0] mem [DELAY_DEPTH];

  logic [PHASE_W-1:0]            sample_count;
  logic [AW-1:0]                 write_index;
  logic                          filled;

  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic [PHASE_W-1:0]            phase_r;
  logic signed [BASE_W-1:0]      base_r;
  logic [BIASED_W-1:0]           biased_r;
  logic [FRAC_W-1:0]             frac_r;
  logic                          va_r;
  logic                          vb_r;
  logic signed [SAMPLE_BITS-1:0] rd_a;
  logic signed [SAMPLE_BITS-1:0] rd_b;

  logic [PRODW-1:0]              mod_prod;
  logic [XW-1:0]                 pos_x;
  logic [PW-1:0]                 pos;
  logic [AW-1:0]                 addr_a;
  logic [AW-1:0]                 addr_b;
  logic [FRAC_W:0]               w_a;
  logic [FRAC_W:0]               w_b;
  logic signed [SAMPLE_BITS-1:0] a_m;
  logic signed [SAMPLE_BITS-1:0] b_m;
  logic signed [SW-1:0]          prod_a;
  logic signed [SW-1:0]          prod_b;
  logic signed [SW-1:0]          sum;

  assign mod_prod = PRODW'(depth_q8) * PRODW'(phase_r ^ {1'b1, {(PHASE_W-1){1'b0}}});

  always_comb begin
    pos_x = XW'({write_index, {FRAC_W{1'b0}}})
          - {{(XW-BASE_W){base_r[BASE_W-1]}}, base_r}
          - XW'(biased_r);
    pos    = pos_x[PW-1:0];
    addr_a = pos[PW-1:FRAC_W];
    addr_b = addr_a + 1'b1;
  end

  always_comb begin
    w_b    = {1'b0, frac_r};
    w_a    = {1'b1, {FRAC_W{1'b0}}} - w_b;
    a_m    = va_r ? rd_a : '0;
    b_m    = vb_r ? rd_b : '0;
    prod_a = SW'($signed({1'b0, w_a})) * SW'(a_m);
    prod_b = SW'($signed({1'b0, w_b})) * SW'(b_m);
    sum    = prod_a + prod_b + SW'(1 << (FRAC_W - 1));
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= sample_in;
      phase_r  <= PHASE_W'(sample_count * rate_increment);
      base_r   <= BASE_W'(predelay_q8) - BASE_W'(depth_q8);
    end
    if (cmd.load_mod) begin
      biased_r <= mod_prod[PRODW-1:PHASE_W-1];
    end
    if (cmd.load_addr) begin
      frac_r <= pos[FRAC_W-1:0];
      va_r   <= filled || (addr_a < write_index);
      vb_r   <= filled || (addr_b < write_index);
    end
    if (cmd.finish) begin
      sample_out <= sum[SAMPLE_BITS+FRAC_W-1:FRAC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_addr) begin
      rd_a <= mem[addr_a];
      rd_b <= mem[addr_b];
    end
    if (cmd.finish) begin
      mem[write_index] <= sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      write_index  <= '0;
      filled       <= 1'b0;
    end else if (cmd.finish) begin
      sample_count <= sample_count + 1'b1;
      write_index  <= write_index + 1'b1;
      if (&write_index) filled <= 1'b1;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/sawtooth_modulated_flanger.sv */
`default_nettype none
// Channel     Handshake                       Payload
// ---------   -----------------------------   ------------------------------------
// input       in_valid / in_ready             sample_in
// output      out_valid / out_ready           sample_out
// config      psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// Steps of a request, in order: accept with the phase multiply, the depth multiply,
// the address add with the two delay-memory reads, then interpolation and write-back.
// A new request is taken while a finished result waits; a stalled output holds the
// interpolation step. Reset clears the counter and write index at once; memory entries
// not yet written read as zero through a fill mark, so there is no clearing pass.
// DELAY_DEPTH is a power of two.

module sawtooth_modulated_flanger #(
  parameter int DELAY_DEPTH = 2048,
  parameter int SAMPLE_BITS = 24
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire signed [SAMPLE_BITS-1:0]     sample_in,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic signed [SAMPLE_BITS-1:0]    sample_out,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire        [smf_pkg::PADDR_W-1:0] paddr,
  input  wire        [smf_pkg::PDATA_W-1:0] pwdata,
  output logic       [smf_pkg::PDATA_W-1:0] prdata,
  output logic                             pready
);
  import smf_pkg::*;

  `include "sawtooth_modulated_flanger_macros.svh"

  logic [DEPTH_W-1:0]    depth_q8;
  logic [PREDELAY_W-1:0] predelay_q8;
  logic [RATE_W-1:0]     rate_increment;
  logic                  cfg_wr;
  logic [1:0]            reg_sel;
  smf_cmd_t              cmd;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_q8       <= '0;
      predelay_q8    <= '0;
      rate_increment <= RATE_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_DEPTH:    depth_q8       <= pwdata[DEPTH_W-1:0];
        REG_PREDELAY: predelay_q8    <= pwdata[PREDELAY_W-1:0];
        REG_RATE:     rate_increment <= pwdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_DEPTH:    prdata = PDATA_W'(depth_q8);
      REG_PREDELAY: prdata = PDATA_W'(predelay_q8);
      REG_RATE:     prdata = PDATA_W'(rate_increment);
      default:      prdata = '0;
    endcase
  end

  smf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  smf_datapath #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .depth_q8       (depth_q8),
    .predelay_q8    (predelay_q8),
    .rate_increment (rate_increment),
    .sample_in      (sample_in),
    .sample_out     (sample_out)
  );

  `SMF_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `SMF_ASSERT_NEXT(a_result_loaded, clk, rst, cmd.finish, out_valid)
  `SMF_ASSERT_SAME(a_finish_not_idle, clk, rst, cmd.finish, !in_ready)
  `SMF_ASSERT_NEXT(a_depth_write, clk, rst, cfg_wr && (reg_sel == REG_DEPTH), depth_q8 == $past(pwdata[DEPTH_W-1:0]))

endmodule

`default_nettype wire
